// ===== rtl/itrt_pkg.sv =====
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and helpers for the integer to radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int RADIX_BITS  = 6;
   localparam int CHAR_BITS   = 7;
   localparam int DIGIT_BITS  = 6;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEP    = 8;
   localparam int DIV_CYCLES  = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int PAD_BITS    = DIV_CYCLES * DIV_STEP;
   localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam int COUNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam int IDX_BITS    = $clog2(VALUE_BITS);

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = CHAR_BITS'(8'h2D);
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(8'h30);
   localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = CHAR_BITS'(8'h61);
   localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = DIGIT_BITS'(9);
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = DIGIT_BITS'(10);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0]        radix;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      logic push_sign;
      logic push_digit;
   } itrt_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic negative;
      logic quot_next_zero;
      logic last_digit;
   } itrt_status_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d > DIGIT_NINE) begin
         c = CHAR_LOW_A + CHAR_BITS'(d - DIGIT_TEN);
      end else begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end
      return c;
   endfunction

endpackage

// ===== rtl/itrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// itrt_ctrl
// Sequencer: accepts a word, runs the digit divisions, then emits characters.
// ----------------------------------------------------------------------------
module itrt_ctrl import itrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  itrt_status_type status,
   output itrt_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
               cmd.div_last = 1'b1;
               div_cnt_in   = '0;
               if (status.quot_next_zero) begin
                  state_in = status.negative ? ST_SIGN : ST_DIGIT;
               end
            end else begin
               div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
            end
         end
         ST_SIGN: begin
            if (status.slot_free) begin
               cmd.push_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.slot_free) begin
               cmd.push_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// ===== rtl/itrt_dpath.sv =====
// ----------------------------------------------------------------------------
// itrt_dpath
// Magnitude divider, digit buffer and the output word register.
// ----------------------------------------------------------------------------
module itrt_dpath import itrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  itrt_cmd_type    cmd,
   output itrt_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [PAD_BITS-1:0]   work_ff;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [RADIX_BITS-1:0] radix_ff;
   logic                  neg_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [DIGIT_BITS-1:0] digit_buf [VALUE_BITS];
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   logic [VALUE_BITS-1:0] value_u;
   logic [VALUE_BITS-1:0] magnitude;
   logic [RADIX_BITS-1:0] radix_sat;
   logic [PAD_BITS-1:0]   work_n;
   logic [DIGIT_BITS-1:0] rem_n;
   logic [DIGIT_BITS:0]   trial;
   logic [IDX_BITS-1:0]   wr_idx;
   logic [IDX_BITS-1:0]   rd_idx;
   logic [COUNT_BITS-1:0] count_dec;

   assign value_u   = VALUE_BITS'(req_data.value);
   assign magnitude = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u) : value_u;

   always_comb begin
      if (req_data.radix < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (req_data.radix > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = req_data.radix;
      end
   end

   // restoring division, DIV_STEP quotient bits per cycle, quotient shifts in low
   always_comb begin
      work_n = work_ff;
      rem_n  = rem_ff;
      trial  = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial  = {rem_n, work_n[PAD_BITS-1]};
         work_n = {work_n[PAD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            rem_n     = DIGIT_BITS'(trial - {1'b0, radix_ff});
            work_n[0] = 1'b1;
         end else begin
            rem_n = trial[DIGIT_BITS-1:0];
         end
      end
   end

   assign count_dec = count_ff - COUNT_BITS'(1);
   assign wr_idx    = count_ff[IDX_BITS-1:0];
   assign rd_idx    = count_dec[IDX_BITS-1:0];

   assign status.slot_free      = !rsp_valid_ff || rsp_ready;
   assign status.negative       = neg_ff;
   assign status.quot_next_zero = (work_n == '0);
   assign status.last_digit     = (count_ff == COUNT_BITS'(1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff  <= PAD_BITS'(magnitude);
         rem_ff   <= '0;
         radix_ff <= radix_sat;
         neg_ff   <= value_u[VALUE_BITS-1];
      end else if (cmd.div_step) begin
         work_ff <= work_n;
         rem_ff  <= cmd.div_last ? '0 : rem_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && cmd.div_last) begin
         digit_buf[wr_idx] <= rem_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.div_step && cmd.div_last) begin
         count_ff <= count_ff + COUNT_BITS'(1);
      end else if (cmd.push_digit) begin
         count_ff <= count_dec;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_sign || cmd.push_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_sign) begin
         rsp_data_ff.char_code <= CHAR_MINUS;
         rsp_data_ff.last      <= 1'b0;
      end else if (cmd.push_digit) begin
         rsp_data_ff.char_code <= digit_char(digit_buf[rd_idx]);
         rsp_data_ff.last      <= status.last_digit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/integer_to_radix_text_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Signed integer to base 2..36 ASCII text, one character per output word.
//
//  channel  ports                               direction  payload
//  req      req_valid, req_ready, req_data      in         value, radix
//  rsp      rsp_valid, rsp_ready, rsp_data      out        char_code, last
//
// one word at a time: a load, then a full divider pass per digit (8 quotient
// bits per cycle over the 32-bit magnitude), then the sign if negative and the
// characters, which wait while rsp stalls; the iterative divider sets the bulk
// of the conversion time.
// req_ready rises once the last character sits in the output register.
// synchronous active-high reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top import itrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   itrt_cmd_type    cmd;
   itrt_status_type status;

   itrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itrt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
